[src/kft_pkg.sv]
`timescale 1ns / 1ps
// kft_pkg: request codes and field widths for the keyed fact table
// no dependencies; imported by keyed_fact_table and its checker

package kft_pkg;

    localparam int KEY_W = 8;
    localparam int VAL_W = 8;
    localparam int REQ_W = 2;

    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_GET    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NONE   = 2'd3;

    // input tdata bit positions
    localparam int S_REQ_LSB = 0;
    localparam int S_KEY_LSB = S_REQ_LSB + REQ_W;
    localparam int S_VAL_LSB = S_KEY_LSB + KEY_W;
    localparam int S_DATA_W  = 24;

    // result tdata bit positions
    localparam int M_HIT_BIT  = VAL_W;
    localparam int M_FULL_BIT = VAL_W + 1;
    localparam int M_DATA_W   = 16;

    typedef logic [KEY_W-1:0]        key_t;
    typedef logic signed [VAL_W-1:0] val_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } entry_t;

endpackage

[src/keyed_fact_table.sv]
`timescale 1ns / 1ps
// keyed_fact_table: packed key/value table with add, get and remove requests
// depends on kft_pkg; entries live in one two-port memory scanned in order
//
// usage:
//   s_ channel takes one request item: req_type, key, value
//   m_ channel returns exactly one result item per request:
//     read_value, hit, full_error
//   cfg_ channel writes the unknown_code register (value of a get miss);
//   write it only while no request is in flight
// sequencing:
//   the scan visits each entry with a registered memory read and then a key
//   compare; a hit ends the scan at that entry, a miss ends it after the n
//   stored entries
//   a remove then moves each later entry down one place through the same
//   memory, with a read of the entry and then its write to the place below
//   s_tready is high only while the sequencer is idle
// reset:
//   aresetn clears the entry count, the sequencer and the result valid;
//   unknown_code returns to -1; entry storage is not cleared
// stalls:
//   a finished result sits in the output register until m_tready; the next
//   request is already accepted meanwhile, and its result waits at the end
//   of its scan until the output register frees up

module keyed_fact_table
    import kft_pkg::*;
#(
    parameter int ENTRIES = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // request items
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // req_type[1:0], key[9:2], value[17:10], zero pad
    // result items
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // read_value[7:0], hit[8], full_error[9], zero pad
    // unknown_code register write
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [VAL_W-1:0]     cfg_data   // unknown_code[7:0]
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ENTRIES);

    // sequencer codes
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;  // issue read of entry at ptr
    localparam logic [2:0] ST_CMP    = 3'd2;  // compare key of entry at ptr
    localparam logic [2:0] ST_SH_RD  = 3'd3;  // remove: read entry ptr+1
    localparam logic [2:0] ST_SH_WR  = 3'd4;  // remove: write it to ptr
    localparam logic [2:0] ST_DONE   = 3'd5;  // hand result to output register

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic [REQ_W-1:0]  req_reg, req_next;
    key_t              key_reg, key_next;
    val_t              val_reg, val_next;
    val_t              unknown_reg;

    // pending result of the request in work
    val_t              res_val_reg, res_val_next;
    logic              res_hit_reg, res_hit_next;
    logic              res_full_reg, res_full_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    val_t              m_val_reg, m_val_next;
    logic              m_hit_reg, m_hit_next;
    logic              m_full_reg, m_full_next;

    // entry memory, one port each for read and write
    entry_t            mem [ENTRIES];
    entry_t            mem_q;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  wr_addr;
    logic              wr_en;
    entry_t            wr_data;

    logic              in_fire;
    logic [CNT_W-1:0]  ptr_inc;
    logic              key_match;
    logic              out_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid && s_tready;
    assign ptr_inc   = ptr_reg + CNT_W'(1);
    assign key_match = (mem_q.key == key_reg);
    assign out_free  = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W - VAL_W - 2){1'b0}}, m_full_reg, m_hit_reg, m_val_reg};

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        mem_q <= mem[rd_addr];
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        req_next      = req_reg;
        key_next      = key_reg;
        val_next      = val_reg;
        res_val_next  = res_val_reg;
        res_hit_next  = res_hit_reg;
        res_full_next = res_full_reg;
        m_valid_next  = m_valid_reg;
        m_val_next    = m_val_reg;
        m_hit_next    = m_hit_reg;
        m_full_next   = m_full_reg;
        rd_addr       = ptr_reg[IDX_W-1:0];
        wr_addr       = ptr_reg[IDX_W-1:0];
        wr_en         = 1'b0;
        wr_data       = '{key: key_reg, value: val_reg};

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    req_next      = s_tdata[S_REQ_LSB +: REQ_W];
                    key_next      = s_tdata[S_KEY_LSB +: KEY_W];
                    val_next      = s_tdata[S_VAL_LSB +: VAL_W];
                    ptr_next      = '0;
                    res_val_next  = '0;
                    res_hit_next  = 1'b0;
                    res_full_next = 1'b0;
                    // unused request code: all-zero result straight away
                    if (s_tdata[S_REQ_LSB +: REQ_W] == REQ_NONE) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                if (ptr_reg == count_reg) begin
                    // end of table, key absent
                    state_next = ST_DONE;
                    case (req_reg)
                        REQ_ADD: begin
                            if (count_reg != FULL_COUNT) begin
                                wr_en      = 1'b1;
                                wr_addr    = count_reg[IDX_W-1:0];
                                count_next = count_reg + CNT_W'(1);
                            end else begin
                                res_full_next = 1'b1;
                            end
                        end
                        REQ_GET: begin
                            res_val_next = unknown_reg;
                        end
                        default: begin
                        end
                    endcase
                end else begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                if (key_match) begin
                    res_hit_next = 1'b1;
                    case (req_reg)
                        REQ_ADD: begin
                            wr_en      = 1'b1;
                            state_next = ST_DONE;
                        end
                        REQ_GET: begin
                            res_val_next = val_t'(mem_q.value);
                            state_next   = ST_DONE;
                        end
                        default: begin
                            state_next = ST_SH_RD;
                        end
                    endcase
                end else begin
                    ptr_next   = ptr_inc;
                    state_next = ST_READ;
                end
            end
            ST_SH_RD: begin
                rd_addr = ptr_inc[IDX_W-1:0];
                if (ptr_inc < count_reg) begin
                    state_next = ST_SH_WR;
                end else begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = ST_DONE;
                end
            end
            ST_SH_WR: begin
                wr_en      = 1'b1;
                wr_data    = mem_q;
                ptr_next   = ptr_inc;
                state_next = ST_SH_RD;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_val_next   = res_val_reg;
                    m_hit_next   = res_hit_reg;
                    m_full_next  = res_full_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            unknown_reg <= -8'sd1;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                unknown_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg      <= ptr_next;
        req_reg      <= req_next;
        key_reg      <= key_next;
        val_reg      <= val_next;
        res_val_reg  <= res_val_next;
        res_hit_reg  <= res_hit_next;
        res_full_reg <= res_full_next;
        m_val_reg    <= m_val_next;
        m_hit_reg    <= m_hit_next;
        m_full_reg   <= m_full_next;
    end

endmodule

[src/kft_checker.sv]
`timescale 1ns / 1ps
// kft_checker: port-level assertions for keyed_fact_table
// depends on kft_pkg; bound to the top level at the end of this file

module kft_checker
    import kft_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // a found key never also reports a full table
    a_hit_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[M_HIT_BIT] && m_tdata[M_FULL_BIT]))
        else $error("hit and full_error both set");

    // a refused append returns a zero value
    a_full_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[M_FULL_BIT] |-> m_tdata[VAL_W-1:0] == '0)
        else $error("full_error with nonzero read_value");

    // one request at a time: not ready right after taking an item
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

    // reset empties the result register
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind keyed_fact_table kft_checker u_kft_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
